// ===== design/mgeb_pkg.sv =====
package mgeb_pkg;

  localparam int QONE = 65536;

  // Shared multiplier ops: an ordinary node's in order, then node 0's.
  typedef enum logic [3:0] {
    OP_SUB,
    OP_COEF,
    OP_DETA,
    OP_T1,
    OP_TDT,
    OP_DQD,
    OP_GAIN,
    OP_T2,
    OP_KSP,
    OP_POS,
    OP_RG,
    OP_RS,
    OP_FR
  } mul_op_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007fffffff) r = 32'sh7fffffff;
    else if (v < -64'sh0000000080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Floor of a product shifted right, saturated.
  function automatic logic signed [31:0] qshift(input logic signed [63:0] p,
                                                input logic central);
    logic signed [63:0] s;
    s = central ? (p >>> 17) : (p >>> 16);
    return sat64(s);
  endfunction

  // Commands from controller to datapath.
  typedef struct packed {
    logic    load;
    logic    mul_go;
    mul_op_t mul_op;
    logic    div_go;
    logic    div_sel;
    logic    second;
    logic    shift;
  } ctl_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ===== design/mgeb_div.sv =====
module mgeb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic signed [31:0] den,
  output logic        done,
  output logic signed [31:0] quo
);
  // Restoring divider of 2^32 by |den|, one quotient bit per cycle.
  logic [31:0] rem;
  logic [32:0] q;
  logic [31:0] d;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic signed [63:0] mag;
  logic signed [63:0] sq;

  // The dividend is a one followed by 32 zeros.
  assign trial = {rem, (cnt == 6'd32)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      q    <= '0;
      d    <= '0;
      neg  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        q    <= '0;
        neg  <= den[31];
        d    <= den[31] ? 32'(-den) : den;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= 32'(trial - {1'b0, d});
          q   <= {q[31:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          q   <= {q[31:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  // Sign fix and saturation; a zero divisor gives zero.
  always_comb begin
    mag = $signed(64'(q));
    sq  = neg ? -mag : mag;
    if (d == 32'd0) quo = '0;
    else quo = mgeb_pkg::sat64(sq);
  end
endmodule

// ===== design/mgeb_datapath.sv =====
module mgeb_datapath #(
  parameter int GRAVEL_NODES = 32,
  parameter int CW = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  mgeb_pkg::ctl_t ctl,
  output mgeb_pkg::sts_t sts,
  input  logic [CW-1:0] k_in,
  input  logic        gravel,
  input  logic        edge_node,
  input  logic signed [31:0] node_eta,
  input  logic signed [31:0] node_flux,
  input  logic [16:0] node_xbar,
  input  logic signed [31:0] front_speed,
  input  logic signed [31:0] gravel_ghost_flux,
  input  logic signed [31:0] sand_ghost_flux,
  input  logic        first,
  input  logic [30:0] time_step,
  input  logic signed [31:0] subsidence_rate,
  input  logic [16:0] gravel_spacing,
  input  logic [16:0] sand_spacing,
  input  logic [30:0] basin_length,
  input  logic [30:0] gravel_gain,
  input  logic [30:0] sand_gain,
  output logic signed [31:0] new_eta,
  output logic signed [31:0] node_position
);
  logic signed [31:0] e0, e1, f0, f1, ein, qin;
  logic [16:0] xh, xin;
  logic signed [31:0] spd, gg, sg, rc0, rc1, front;
  logic signed [31:0] v, t, deta, dqd, kspc, den;
  logic signed [63:0] prod;
  mgeb_pkg::mul_op_t op_q;
  logic go_q;
  logic cen, cen_q;
  logic div_done;
  logic signed [31:0] quo;

  logic signed [31:0] rc, gain, xc, coef, span, dt, cur_eta, ediff, dq, a, b, pshift;
  logic [CW-1:0] kk;

  assign dt   = $signed({1'b0, time_step});
  assign rc   = gravel ? rc0 : rc1;
  assign gain = gravel ? $signed({1'b0, gravel_gain}) : $signed({1'b0, sand_gain});
  assign xc   = $signed({15'b0, (ctl.second ? xin : xh)});
  assign coef = gravel ? xc : mgeb_pkg::sat64(64'(mgeb_pkg::QONE) - 64'(xc));
  assign span = mgeb_pkg::sat64(64'($signed({1'b0, basin_length})) - 64'(front));
  assign kk   = gravel ? k_in : CW'(k_in - CW'(GRAVEL_NODES));

  // Elevation, slope and divergence operands of the node being emitted.
  assign cur_eta = ctl.second ? ein : e1;

  always_comb begin
    if (ctl.second) begin
      ediff = mgeb_pkg::sat64(64'(ein) - 64'(e1));
      dq    = mgeb_pkg::sat64(64'(qin) - 64'(f1));
    end else if (edge_node) begin
      ediff = mgeb_pkg::sat64(64'(ein) - 64'(e1));
      dq    = mgeb_pkg::sat64(64'(f1) - 64'(gravel ? gg : sg));
    end else begin
      ediff = mgeb_pkg::sat64(64'(ein) - 64'(e0));
      dq    = mgeb_pkg::sat64(64'(f1) - 64'(f0));
    end
  end

  // Shared multiplier operand mux.
  always_comb begin
    a = '0;
    b = '0;
    cen = 1'b0;
    unique case (ctl.mul_op)
      mgeb_pkg::OP_SUB:  begin a = subsidence_rate; b = dt; end
      mgeb_pkg::OP_COEF: begin a = coef; b = spd; end
      mgeb_pkg::OP_DETA: begin a = ediff; b = rc; cen = ~edge_node & ~ctl.second; end
      mgeb_pkg::OP_T1:   begin a = t; b = deta; end
      mgeb_pkg::OP_TDT:  begin a = t; b = dt; end
      mgeb_pkg::OP_DQD:  begin a = dq; b = rc; end
      mgeb_pkg::OP_GAIN: begin a = gain; b = dqd; end
      mgeb_pkg::OP_T2:   begin a = t; b = dt; end
      mgeb_pkg::OP_KSP:  begin
        a = gravel ? $signed({15'b0, gravel_spacing}) : $signed({15'b0, sand_spacing});
        b = $signed(32'(kk));
      end
      mgeb_pkg::OP_POS:  begin a = kspc; b = gravel ? front : span; end
      mgeb_pkg::OP_RG:   begin a = $signed({15'b0, gravel_spacing}); b = front; end
      mgeb_pkg::OP_RS:   begin a = $signed({15'b0, sand_spacing}); b = span; end
      mgeb_pkg::OP_FR:   begin a = spd; b = dt; end
      default: ;
    endcase
  end

  // Product register; the operation tag is registered alongside it.
  always_ff @(posedge clk) begin
    prod  <= 64'(a) * 64'(b);
    op_q  <= ctl.mul_op;
    cen_q <= cen;
  end

  assign pshift = mgeb_pkg::qshift(prod, cen_q);

  mgeb_div u_div (
    .clk(clk), .rst(rst), .start(ctl.div_go), .den(den), .done(div_done), .quo(quo)
  );
  assign sts.div_done = div_done;

  // Node capture, product write-back, reciprocals and window shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= 32'(mgeb_pkg::QONE);
      e0 <= '0; e1 <= '0; f0 <= '0; f1 <= '0; ein <= '0; qin <= '0;
      xh <= '0; xin <= '0;
      spd <= '0; gg <= '0; sg <= '0; rc0 <= '0; rc1 <= '0;
      v <= '0; t <= '0; deta <= '0; dqd <= '0; kspc <= '0; den <= '0;
      new_eta <= '0; node_position <= '0;
      go_q <= 1'b0;
    end else begin
      go_q <= ctl.mul_go;
      if (ctl.load) begin
        ein <= node_eta;
        qin <= node_flux;
        xin <= node_xbar;
        if (first) begin
          spd <= front_speed; gg <= gravel_ghost_flux; sg <= sand_ghost_flux;
        end
      end
      if (go_q) begin
        unique case (op_q)
          mgeb_pkg::OP_SUB:  v <= mgeb_pkg::sat64(64'(cur_eta) - 64'(pshift));
          mgeb_pkg::OP_COEF: t <= pshift;
          mgeb_pkg::OP_DETA: deta <= pshift;
          mgeb_pkg::OP_T1:   t <= pshift;
          mgeb_pkg::OP_TDT:  v <= mgeb_pkg::sat64(64'(v) + 64'(pshift));
          mgeb_pkg::OP_DQD:  dqd <= pshift;
          mgeb_pkg::OP_GAIN: t <= pshift;
          mgeb_pkg::OP_T2:   new_eta <= mgeb_pkg::sat64(64'(v) - 64'(pshift));
          mgeb_pkg::OP_KSP:  kspc <= mgeb_pkg::sat64(prod);
          mgeb_pkg::OP_POS:  node_position <= gravel ? pshift
                                 : mgeb_pkg::sat64(64'(front) + 64'(pshift));
          mgeb_pkg::OP_RG, mgeb_pkg::OP_RS: den <= pshift;
          mgeb_pkg::OP_FR:   front <= mgeb_pkg::sat64(64'(front) + 64'(pshift));
          default: ;
        endcase
      end
      if (div_done) begin
        if (ctl.div_sel) rc1 <= quo;
        else rc0 <= quo;
      end
      if (ctl.shift) begin
        e0 <= e1; e1 <= ein; f0 <= f1; f1 <= qin; xh <= xin;
      end
    end
  end
endmodule

// ===== design/mgeb_ctrl.sv =====
module mgeb_ctrl #(
  parameter int GRAVEL_NODES = 32,
  parameter int SAND_NODES = 32,
  parameter int CW = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic last_result,
  output mgeb_pkg::ctl_t ctl,
  input  mgeb_pkg::sts_t sts,
  output logic [CW-1:0] k_out,
  output logic gravel,
  output logic edge_node,
  output logic first
);
  localparam int TOTAL = GRAVEL_NODES + SAND_NODES + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ISSUE  = 7'b0000010,
    S_WB     = 7'b0000100,
    S_DSTART = 7'b0001000,
    S_DWAIT  = 7'b0010000,
    S_OUT    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  logic [CW-1:0] n;
  mgeb_pkg::mul_op_t op;
  logic second;

  // Index of the node being emitted: the previous node, or the end node itself.
  assign first       = (n == '0);
  assign k_out       = second ? n : CW'(n - CW'(1));
  assign gravel      = k_out < CW'(GRAVEL_NODES);
  assign edge_node   = !second && ((k_out == '0) || (k_out == CW'(GRAVEL_NODES)));
  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign last_result = second;

  // Commands to the datapath.
  always_comb begin
    ctl = '0;
    ctl.load    = in_valid && (state == S_IDLE);
    ctl.mul_go  = (state == S_ISSUE);
    ctl.mul_op  = op;
    ctl.div_go  = (state == S_DSTART);
    ctl.div_sel = (op == mgeb_pkg::OP_RS);
    ctl.second  = second;
    ctl.shift   = (state == S_DONE) && !second;
  end

  // Each product is issued and then written back before the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      op <= mgeb_pkg::OP_SUB;
      second <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= first ? mgeb_pkg::OP_RG : mgeb_pkg::OP_SUB;
          state <= S_ISSUE;
        end
        S_ISSUE: state <= S_WB;
        S_WB: begin
          unique case (op)
            mgeb_pkg::OP_SUB:  begin op <= mgeb_pkg::OP_COEF; state <= S_ISSUE; end
            mgeb_pkg::OP_COEF: begin op <= mgeb_pkg::OP_DETA; state <= S_ISSUE; end
            mgeb_pkg::OP_DETA: begin op <= mgeb_pkg::OP_T1;   state <= S_ISSUE; end
            mgeb_pkg::OP_T1:   begin op <= mgeb_pkg::OP_TDT;  state <= S_ISSUE; end
            mgeb_pkg::OP_TDT:  begin op <= mgeb_pkg::OP_DQD;  state <= S_ISSUE; end
            mgeb_pkg::OP_DQD:  begin op <= mgeb_pkg::OP_GAIN; state <= S_ISSUE; end
            mgeb_pkg::OP_GAIN: begin op <= mgeb_pkg::OP_T2;   state <= S_ISSUE; end
            mgeb_pkg::OP_T2:   begin op <= mgeb_pkg::OP_KSP;  state <= S_ISSUE; end
            mgeb_pkg::OP_KSP:  begin op <= mgeb_pkg::OP_POS;  state <= S_ISSUE; end
            mgeb_pkg::OP_POS:  state <= S_OUT;
            mgeb_pkg::OP_RG, mgeb_pkg::OP_RS: state <= S_DSTART;
            mgeb_pkg::OP_FR:   state <= S_DONE;
            default: state <= S_IDLE;
          endcase
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: if (sts.div_done) begin
          op <= (op == mgeb_pkg::OP_RG) ? mgeb_pkg::OP_RS : mgeb_pkg::OP_FR;
          state <= S_ISSUE;
        end
        S_OUT: if (out_ready) begin
          if (n == CW'(TOTAL - 1) && !second) begin
            second <= 1'b1;
            op <= mgeb_pkg::OP_SUB;
            state <= S_ISSUE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (second) begin
            n <= '0;
            second <= 1'b0;
          end else begin
            n <= CW'(n + CW'(1));
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/moving_grid_exner_bed_update.sv =====
// Channel | Handshake             | Fields                                | Word
// in      | in_valid / in_ready   | node_eta .. sand_ghost_flux           | one node
// out     | out_valid / out_ready | new_eta, node_position, last_result   | one result
// cfg     | psel/penable/pwrite   | paddr, pwdata, prdata; pready is high | one register
// Each result takes ten products on one shared multiplier, each issued and then written back.
// An ordinary node gives one result and the end node two; node 0 gives none, as it runs
// two 33-step reciprocal divisions and the front update instead.
// While a result waits for out_ready, no node is taken.
// Reset is synchronous and restores register defaults and a front of 1.0.
module moving_grid_exner_bed_update #(
  parameter int GRAVEL_NODES = 32,
  parameter int SAND_NODES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] node_eta,
  input  logic signed [31:0] node_flux,
  input  logic [16:0] node_xbar,
  input  logic signed [31:0] front_speed,
  input  logic signed [31:0] gravel_ghost_flux,
  input  logic signed [31:0] sand_ghost_flux,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] new_eta,
  output logic signed [31:0] node_position,
  output logic last_result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int CW = $clog2(GRAVEL_NODES + SAND_NODES + 1);

  logic [30:0] time_step, basin_length, gravel_gain, sand_gain;
  logic signed [31:0] subsidence_rate;
  logic [16:0] gravel_spacing, sand_spacing;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 31'd65536; subsidence_rate <= '0;
      gravel_spacing <= 17'd2048; sand_spacing <= 17'd2048;
      basin_length <= 31'd65536; gravel_gain <= 31'd65536; sand_gain <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        3'd0: time_step <= pwdata[30:0];
        3'd1: subsidence_rate <= pwdata;
        3'd2: gravel_spacing <= pwdata[16:0];
        3'd3: sand_spacing <= pwdata[16:0];
        3'd4: basin_length <= pwdata[30:0];
        3'd5: gravel_gain <= pwdata[30:0];
        3'd6: sand_gain <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[4:2])
      3'd0: prdata = {1'b0, time_step};
      3'd1: prdata = subsidence_rate;
      3'd2: prdata = {15'b0, gravel_spacing};
      3'd3: prdata = {15'b0, sand_spacing};
      3'd4: prdata = {1'b0, basin_length};
      3'd5: prdata = {1'b0, gravel_gain};
      3'd6: prdata = {1'b0, sand_gain};
      default: prdata = '0;
    endcase
  end

  mgeb_pkg::ctl_t ctl;
  mgeb_pkg::sts_t sts;
  logic [CW-1:0] k;
  logic gravel, edge_node, first;

  mgeb_ctrl #(.GRAVEL_NODES(GRAVEL_NODES), .SAND_NODES(SAND_NODES), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .last_result(last_result),
    .ctl(ctl), .sts(sts), .k_out(k), .gravel(gravel), .edge_node(edge_node),
    .first(first)
  );

  mgeb_datapath #(.GRAVEL_NODES(GRAVEL_NODES), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .k_in(k), .gravel(gravel),
    .edge_node(edge_node), .node_eta(node_eta),
    .node_flux(node_flux), .node_xbar(node_xbar), .front_speed(front_speed),
    .gravel_ghost_flux(gravel_ghost_flux), .sand_ghost_flux(sand_ghost_flux),
    .first(first), .time_step(time_step), .subsidence_rate(subsidence_rate),
    .gravel_spacing(gravel_spacing), .sand_spacing(sand_spacing),
    .basin_length(basin_length), .gravel_gain(gravel_gain), .sand_gain(sand_gain),
    .new_eta(new_eta), .node_position(node_position)
  );
endmodule
